@@ rtl/pss_pkg.sv @@
// Package for the PCM sample statistics block: payload structs, command
// codes and fixed widths shared by all modules but the FIFO. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pss_pkg;

  // Fixed field widths
  localparam int SAMPLE_W  = 24;
  localparam int SUM_W     = 56;
  localparam int SQ_W      = 64;
  localparam int CNT_OUT_W = 32;
  localparam int PROD_W    = 2 * SAMPLE_W;

  // Input op codes
  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Sample width modes
  localparam logic MODE_16 = 1'b0;
  localparam logic MODE_24 = 1'b1;
  localparam logic MODE_RESET = MODE_24;

  // Statistic reset values and sum saturation limits
  localparam logic signed [SAMPLE_W-1:0] MIN_INIT = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] MAX_INIT = 24'sh800000;
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [CNT_OUT_W-1:0]       samples_seen;
    logic signed [SAMPLE_W-1:0] min_value;
    logic signed [SAMPLE_W-1:0] largest_value;
    logic signed [SUM_W-1:0]    sample_sum;
    logic [SQ_W-1:0]            square_sum;
    logic                       overflowed;
  } out_item_t;

  // Commands from the byte assembler to the statistics engine
  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                  kind;
    logic signed [SAMPLE_W-1:0] sample;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/pcm_sample_statistics.sv @@
// PCM sample statistics, top level. Joins the byte assembler, the command
// queue, the statistics engine and the result queue. Uses pss_pkg.
//
// Usage:
//   Input queue port: in_item (op, data_byte) is taken when in_push is high
//   and in_full is low. Data bytes arrive least significant first; op =
//   clear resets the statistics and the byte position and gives no result.
//   Result queue port: while out_empty is low, out_item holds the oldest
//   result; it is taken when out_pop is high. One result per finished
//   sample carries the sample and the running min, max, count, sum, square
//   sum and the sticky saturation flag.
//   Config port: cfg_we writes cfg_wdata to the width mode (0 = 16-bit,
//   1 = 24-bit); write it only while the block is idle.
//   Throughput: one byte per cycle while in_full is low. A result passes
//   through the command queue, the squaring stage and then the saturating
//   update into the result queue before it is on out_item.
//   Reset: mode 24-bit, statistics cleared, both queues empty.
//   Stall: when the result queue fills, the engine holds, the command queue
//   fills behind it and in_full rises; no item is lost.
`timescale 1ns / 1ps
`default_nettype none

module pcm_sample_statistics #(
  parameter int COUNT_BITS = 32,
  parameter int CMD_DEPTH  = 4,
  parameter int OUT_DEPTH  = 2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic                cfg_wdata,
  input  wire logic                in_push,
  input  wire pss_pkg::in_item_t   in_item,
  output logic                     in_full,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output pss_pkg::out_item_t       out_item
);
  import pss_pkg::*;

  logic      cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t      cmd_wr, cmd_rd;
  logic [$bits(cmd_t)-1:0] cmd_rd_bits;
  logic      res_push, res_full;
  out_item_t res_item;
  logic [$bits(out_item_t)-1:0] out_bits;

  assign in_full  = cmd_full;
  assign cmd_rd   = cmd_t'(cmd_rd_bits);
  assign out_item = out_item_t'(out_bits);

  // Byte assembly
  pss_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_push  (in_push),
    .in_item  (in_item),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd_item (cmd_wr)
  );

  // Command queue between front and back
  pss_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (cmd_push),
    .wr_data(cmd_wr),
    .full   (cmd_full),
    .pop    (cmd_pop),
    .rd_data(cmd_rd_bits),
    .empty  (cmd_empty)
  );

  // Statistics engine
  pss_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_empty(cmd_empty),
    .cmd_item (cmd_rd),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_item (res_item)
  );

  // Result queue
  pss_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (res_push),
    .wr_data(res_item),
    .full   (res_full),
    .pop    (out_pop),
    .rd_data(out_bits),
    .empty  (out_empty)
  );

endmodule

`default_nettype wire

@@ rtl/pss_fifo.sv @@
// Small register-based FIFO used between the front and back parts and as
// the result queue. Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module pss_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pss_front.sv @@
// Front part: holds the width mode register, assembles little-endian bytes
// into signed samples and issues sample or clear commands. Uses pss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pss_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic            cfg_wdata,
  input  wire logic            in_push,
  input  wire pss_pkg::in_item_t in_item,
  input  wire logic            cmd_full,
  output logic                 cmd_push,
  output pss_pkg::cmd_t        cmd_item
);
  import pss_pkg::*;

  logic        mode_r;
  logic [1:0]  pos_r, pos_nxt;
  logic [15:0] held_r, held_nxt;
  logic        accept;
  logic [7:0]  b;

  assign accept = in_push & ~cmd_full;
  assign b      = in_item.data_byte;

  // Byte assembly and command generation
  always_comb begin
    pos_nxt       = pos_r;
    held_nxt      = held_r;
    cmd_push      = 1'b0;
    cmd_item.kind   = CMD_SAMPLE;
    cmd_item.sample = '0;
    if (accept) begin
      if (in_item.op == OP_CLEAR) begin
        pos_nxt       = 2'd0;
        held_nxt      = '0;
        cmd_push      = 1'b1;
        cmd_item.kind = CMD_CLEAR;
      end else if (pos_r == 2'd0) begin
        pos_nxt  = 2'd1;
        held_nxt = {8'h00, b};
      end else if (mode_r == MODE_24 && pos_r == 2'd1) begin
        pos_nxt  = 2'd2;
        held_nxt = {b, held_r[7:0]};
      end else begin
        // sample complete
        pos_nxt  = 2'd0;
        held_nxt = '0;
        cmd_push = 1'b1;
        if (mode_r == MODE_16) begin
          cmd_item.sample = SAMPLE_W'($signed({b, held_r[7:0]}));
        end else begin
          cmd_item.sample = $signed({b, held_r});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET;
      pos_r  <= 2'd0;
      held_r <= '0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      pos_r  <= pos_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pss_back.sv @@
// Back part: squares each sample in a first stage, then updates min, max,
// count, sum and square sum with saturation and issues a result. Uses pss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pss_back #(
  parameter int COUNT_BITS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_empty,
  input  wire pss_pkg::cmd_t cmd_item,
  output logic               cmd_pop,
  input  wire logic          res_full,
  output logic               res_push,
  output pss_pkg::out_item_t res_item
);
  import pss_pkg::*;

  // Stage A: command and its square
  logic                       a_valid_r;
  cmd_kind_t                  a_kind_r;
  logic signed [SAMPLE_W-1:0] a_sample_r;
  logic [PROD_W-1:0]          a_square_r;
  logic signed [PROD_W-1:0]   product;

  // Running statistics
  logic signed [SAMPLE_W-1:0] min_r, min_nxt;
  logic signed [SAMPLE_W-1:0] max_r, max_nxt;
  logic [COUNT_BITS-1:0]      count_r, count_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SQ_W-1:0]            sq_r, sq_nxt;
  logic                       flag_r, flag_nxt;

  logic                       b_go, advance;
  logic signed [SUM_W:0]      sum_wide;
  logic [SQ_W:0]              sq_wide;
  logic                       cnt_sat, sum_sat, sq_sat;
  logic [63:0]                count_ext;

  assign product = cmd_item.sample * cmd_item.sample;
  assign b_go    = a_valid_r & ((a_kind_r == CMD_CLEAR) | ~res_full);
  assign advance = ~a_valid_r | b_go;
  assign cmd_pop = advance & ~cmd_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (advance) begin
      a_valid_r <= ~cmd_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      a_kind_r   <= cmd_item.kind;
      a_sample_r <= cmd_item.sample;
      a_square_r <= $unsigned(product);
    end
  end

  // Stage B: saturating update
  always_comb begin
    cnt_sat  = (count_r == '1);
    sum_wide = (SUM_W+1)'(sum_r) + (SUM_W+1)'(a_sample_r);
    sum_sat  = (sum_wide[SUM_W] != sum_wide[SUM_W-1]);
    sq_wide  = {1'b0, sq_r} + (SQ_W+1)'(a_square_r);
    sq_sat   = sq_wide[SQ_W];

    min_nxt   = (a_sample_r < min_r) ? a_sample_r : min_r;
    max_nxt   = (a_sample_r > max_r) ? a_sample_r : max_r;
    count_nxt = cnt_sat ? count_r : count_r + COUNT_BITS'(1);
    if (sum_sat) begin
      sum_nxt = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_nxt = sum_wide[SUM_W-1:0];
    end
    sq_nxt   = sq_sat ? '1 : sq_wide[SQ_W-1:0];
    flag_nxt = flag_r | cnt_sat | sum_sat | sq_sat;

    count_ext = 64'(count_nxt);
    res_push  = b_go & (a_kind_r == CMD_SAMPLE);
    res_item.sample_value  = a_sample_r;
    res_item.samples_seen  = count_ext[CNT_OUT_W-1:0];
    res_item.min_value     = min_nxt;
    res_item.largest_value = max_nxt;
    res_item.sample_sum    = sum_nxt;
    res_item.square_sum    = sq_nxt;
    res_item.overflowed    = flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r   <= MIN_INIT;
      max_r   <= MAX_INIT;
      count_r <= '0;
      sum_r   <= '0;
      sq_r    <= '0;
      flag_r  <= 1'b0;
    end else if (b_go) begin
      if (a_kind_r == CMD_CLEAR) begin
        min_r   <= MIN_INIT;
        max_r   <= MAX_INIT;
        count_r <= '0;
        sum_r   <= '0;
        sq_r    <= '0;
        flag_r  <= 1'b0;
      end else begin
        min_r   <= min_nxt;
        max_r   <= max_nxt;
        count_r <= count_nxt;
        sum_r   <= sum_nxt;
        sq_r    <= sq_nxt;
        flag_r  <= flag_nxt;
      end
    end
  end

endmodule

`default_nettype wire
